// ===== rtl/core/mctsl_pkg.sv =====
`default_nettype none

package mctsl_pkg;

    localparam int LAYERS   = 64;
    localparam int CHANNELS = 4;
    localparam int TEXTURES = 4;

    localparam int ID_W      = 16;
    localparam int DIM_W     = 13;
    localparam int LVLC_W    = 4;
    localparam int USED_W    = 7;
    localparam int STORE_W   = 30;
    localparam int SLOT_W    = 6;
    localparam int TEX_IN_W  = 8;
    localparam int LVL_IN_W  = 16;
    localparam int OFF_OUT_W = 30;
    localparam int CNT_OUT_W = 27;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam int LAYER_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int TEX_W   = (TEXTURES > 1) ? $clog2(TEXTURES) : 1;
    localparam int UNIT_W  = LAYER_W + TEX_W;

    localparam int LVL_N  = 16;
    localparam int LVL_AW = 4;

    localparam int PROD_W   = 2 * DIM_W;
    localparam int BYTES_W  = PROD_W + $clog2(CHANNELS);
    localparam int STRIDE_W = BYTES_W + LVL_AW;
    localparam int AFTER_W  = STRIDE_W + 1;
    localparam int OFF_W    = UNIT_W + STRIDE_W;
    localparam int SUM_W    = OFF_W + 1;

    localparam int GRP    = 8;
    localparam int GRP_AW = 3;
    localparam int NGRP   = (LAYERS + GRP - 1) / GRP;
    localparam int MPAD   = NGRP * GRP;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_TEX_WIDTH   = 3'd0,
        REG_TEX_HEIGHT  = 3'd1,
        REG_LEVEL_COUNT = 3'd2,
        REG_USED_LAYERS = 3'd3,
        REG_STORE_BYTES = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   tex_width;
        logic [DIM_W-1:0]   tex_height;
        logic [LVLC_W-1:0]  level_count;
        logic [USED_W-1:0]  used_layers;
        logic [STORE_W-1:0] store_bytes;
    } t_cfg;

    typedef struct packed {
        logic [BYTES_W-1:0]  bytes;
        logic [STRIDE_W-1:0] prior;
    } t_lvl_ent;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
    } t_cam_wr;

endpackage

`default_nettype wire

// ===== rtl/core/mctsl_cfg_regs.sv =====
`default_nettype none

module mctsl_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_psel,
    input  wire logic                          i_penable,
    input  wire logic                          i_pwrite,
    input  wire logic [mctsl_pkg::PADDR_W-1:0] i_paddr,
    input  wire logic [mctsl_pkg::PDATA_W-1:0] i_pwdata,
    output logic      [mctsl_pkg::PDATA_W-1:0] o_prdata,
    output mctsl_pkg::t_cfg                    o_cfg,
    output logic                               o_geom_wr
);

    mctsl_pkg::t_cfg     r_cfg;
    mctsl_pkg::t_reg_idx idx;
    logic                wr;

    assign idx = mctsl_pkg::t_reg_idx'(i_paddr[mctsl_pkg::PADDR_W-1:2]);
    assign wr  = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_width   <= mctsl_pkg::DIM_W'(16);
            r_cfg.tex_height  <= mctsl_pkg::DIM_W'(16);
            r_cfg.level_count <= mctsl_pkg::LVLC_W'(5);
            r_cfg.used_layers <= '0;
            r_cfg.store_bytes <= '0;
        end else if (wr) begin
            unique case (idx)
                mctsl_pkg::REG_TEX_WIDTH: begin
                    r_cfg.tex_width <= i_pwdata[mctsl_pkg::DIM_W-1:0];
                end
                mctsl_pkg::REG_TEX_HEIGHT: begin
                    r_cfg.tex_height <= i_pwdata[mctsl_pkg::DIM_W-1:0];
                end
                mctsl_pkg::REG_LEVEL_COUNT: begin
                    r_cfg.level_count <= i_pwdata[mctsl_pkg::LVLC_W-1:0];
                end
                mctsl_pkg::REG_USED_LAYERS: begin
                    r_cfg.used_layers <= i_pwdata[mctsl_pkg::USED_W-1:0];
                end
                mctsl_pkg::REG_STORE_BYTES: begin
                    r_cfg.store_bytes <= i_pwdata[mctsl_pkg::STORE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            mctsl_pkg::REG_TEX_WIDTH:   o_prdata = mctsl_pkg::PDATA_W'(r_cfg.tex_width);
            mctsl_pkg::REG_TEX_HEIGHT:  o_prdata = mctsl_pkg::PDATA_W'(r_cfg.tex_height);
            mctsl_pkg::REG_LEVEL_COUNT: o_prdata = mctsl_pkg::PDATA_W'(r_cfg.level_count);
            mctsl_pkg::REG_USED_LAYERS: o_prdata = mctsl_pkg::PDATA_W'(r_cfg.used_layers);
            mctsl_pkg::REG_STORE_BYTES: o_prdata = mctsl_pkg::PDATA_W'(r_cfg.store_bytes);
            default:                    o_prdata = '0;
        endcase
    end

    assign o_cfg     = r_cfg;
    assign o_geom_wr = wr && (idx == mctsl_pkg::REG_TEX_WIDTH ||
                              idx == mctsl_pkg::REG_TEX_HEIGHT ||
                              idx == mctsl_pkg::REG_LEVEL_COUNT);

endmodule

`default_nettype wire

// ===== rtl/core/mctsl_level_table.sv =====
`default_nettype none

module mctsl_level_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mctsl_pkg::t_cfg               i_cfg,
    input  wire logic                          i_start,
    input  wire logic                          i_rd_en,
    input  wire logic [mctsl_pkg::LVL_AW-1:0]  i_rd_addr,
    output logic                               o_busy,
    output mctsl_pkg::t_lvl_ent                o_rd,
    output logic      [mctsl_pkg::STRIDE_W-1:0] o_stride
);

    localparam logic [mctsl_pkg::LVL_AW:0] IDX_END = (mctsl_pkg::LVL_AW + 1)'(mctsl_pkg::LVL_N);

    logic                                r_busy;
    logic [mctsl_pkg::LVL_AW:0]          r_idx;
    logic                                r_pv;
    logic [mctsl_pkg::LVL_AW-1:0]        r_pidx;
    logic [mctsl_pkg::PROD_W-1:0]        r_prod;
    logic [mctsl_pkg::STRIDE_W-1:0]      r_acc;
    mctsl_pkg::t_lvl_ent                 r_mem [mctsl_pkg::LVL_N];
    mctsl_pkg::t_lvl_ent                 r_q;

    logic [mctsl_pkg::DIM_W-1:0]         n_dw;
    logic [mctsl_pkg::DIM_W-1:0]         n_dh;
    logic [mctsl_pkg::BYTES_W-1:0]       n_bytes;
    logic                                issue;

    assign issue = r_busy && (r_idx != IDX_END);

    always_comb begin
        n_dw = i_cfg.tex_width >> r_idx[mctsl_pkg::LVL_AW-1:0];
        if (n_dw == '0) begin
            n_dw = mctsl_pkg::DIM_W'(1);
        end
        n_dh = i_cfg.tex_height >> r_idx[mctsl_pkg::LVL_AW-1:0];
        if (n_dh == '0) begin
            n_dh = mctsl_pkg::DIM_W'(1);
        end
        n_bytes = mctsl_pkg::BYTES_W'(r_prod) * mctsl_pkg::BYTES_W'(mctsl_pkg::CHANNELS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
            r_pv   <= 1'b0;
            r_acc  <= '0;
        end else begin
            if (issue) begin
                r_pv  <= 1'b1;
                r_idx <= r_idx + 1'b1;
            end else begin
                r_pv <= 1'b0;
                if (!r_pv) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_pv && (r_pidx < i_cfg.level_count)) begin
                r_acc <= r_acc + mctsl_pkg::STRIDE_W'(n_bytes);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_prod <= mctsl_pkg::PROD_W'(n_dw) * mctsl_pkg::PROD_W'(n_dh);
            r_pidx <= r_idx[mctsl_pkg::LVL_AW-1:0];
        end
        if (r_pv) begin
            r_mem[r_pidx] <= '{bytes: n_bytes, prior: r_acc};
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_busy   = r_busy;
    assign o_rd     = r_q;
    assign o_stride = r_acc;

endmodule

`default_nettype wire

// ===== rtl/core/mctsl_layer_cam.sv =====
`default_nettype none

module mctsl_layer_cam (
    input  wire logic                          i_clk,
    input  wire mctsl_pkg::t_cam_wr            i_wr,
    input  wire logic [mctsl_pkg::ID_W-1:0]    i_id,
    input  wire logic [mctsl_pkg::USED_W-1:0]  i_used,
    output logic      [mctsl_pkg::LAYERS-1:0]  o_match
);

    logic [mctsl_pkg::ID_W-1:0] r_ids [mctsl_pkg::LAYERS];

    always_ff @(posedge i_clk) begin
        for (int e = 0; e < mctsl_pkg::LAYERS; e++) begin
            if (i_wr.en && (int'(i_wr.slot) == e)) begin
                r_ids[e] <= i_wr.id;
            end
        end
    end

    always_comb begin
        for (int e = 0; e < mctsl_pkg::LAYERS; e++) begin
            o_match[e] = (r_ids[e] == i_id) && (int'(i_used) > e);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mip_chain_texel_span_locator_unit.sv =====
// Results: each accepted query beat passes six stages to one result beat; store beats give none.
// Throughput: one beat per cycle when not stalled; each stage stalls only when the next is full.
// Reset: synchronous, active low; loads register defaults and rebuilds the 16-entry level
// table, one level per cycle, with o_ready low; a write to tex_width, tex_height or
// level_count starts the same rebuild. Layer ids are undefined until stored.
`default_nettype none

module mip_chain_texel_span_locator_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_op,
    input  wire logic [mctsl_pkg::SLOT_W-1:0]    i_slot,
    input  wire logic [mctsl_pkg::ID_W-1:0]      i_material_id,
    input  wire logic [mctsl_pkg::TEX_IN_W-1:0]  i_texture_slot,
    input  wire logic [mctsl_pkg::LVL_IN_W-1:0]  i_level,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_found,
    output logic      [mctsl_pkg::OFF_OUT_W-1:0] o_byte_offset,
    output logic      [mctsl_pkg::CNT_OUT_W-1:0] o_byte_count,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mctsl_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [mctsl_pkg::PDATA_W-1:0]   pwdata,
    output logic      [mctsl_pkg::PDATA_W-1:0]   prdata,
    output logic                                 pready
);

    mctsl_pkg::t_cfg                      cfg;
    logic                                 geom_wr;
    logic                                 lt_busy;
    mctsl_pkg::t_lvl_ent                  lt_q;
    logic [mctsl_pkg::STRIDE_W-1:0]       lt_stride;
    mctsl_pkg::t_cam_wr                   cam_wr;
    logic [mctsl_pkg::LAYERS-1:0]         cam_match;

    logic in_acc;
    logic adv1, adv2, adv3, adv4, adv5, adv6;

    logic                                 r_v1;
    logic [mctsl_pkg::ID_W-1:0]           r_id1;
    logic [mctsl_pkg::TEX_IN_W-1:0]       r_tex1;
    logic [mctsl_pkg::LVL_IN_W-1:0]       r_lvl1;

    logic                                 r_v2;
    logic [mctsl_pkg::MPAD-1:0]           r_match2;
    logic                                 r_bad2;
    logic [mctsl_pkg::TEX_W-1:0]          r_tex2;

    logic                                 r_v3;
    logic [mctsl_pkg::NGRP-1:0]           r_ghit3;
    logic [mctsl_pkg::GRP_AW-1:0]         r_gidx3 [mctsl_pkg::NGRP];
    logic                                 r_bad3;
    logic [mctsl_pkg::TEX_W-1:0]          r_tex3;
    mctsl_pkg::t_lvl_ent                  r_ent3;

    logic                                 r_v4;
    logic                                 r_ok4;
    logic [mctsl_pkg::UNIT_W-1:0]         r_unit4;
    logic [mctsl_pkg::STRIDE_W-1:0]       r_before4;
    logic [mctsl_pkg::BYTES_W-1:0]        r_bytes4;
    logic [mctsl_pkg::AFTER_W-1:0]        r_after4;

    logic                                 r_v5;
    logic                                 r_ok5;
    logic [mctsl_pkg::OFF_W-1:0]          r_prod5;
    logic [mctsl_pkg::STRIDE_W-1:0]       r_before5;
    logic [mctsl_pkg::BYTES_W-1:0]        r_bytes5;
    logic [mctsl_pkg::AFTER_W-1:0]        r_after5;

    logic                                 r_v6;
    logic                                 r_found6;
    logic [mctsl_pkg::OFF_OUT_W-1:0]      r_off6;
    logic [mctsl_pkg::CNT_OUT_W-1:0]      r_cnt6;

    logic                                 n_bad1;
    logic [mctsl_pkg::NGRP-1:0]           n_ghit;
    logic [mctsl_pkg::GRP_AW-1:0]         n_gidx [mctsl_pkg::NGRP];
    logic                                 n_hit;
    logic [mctsl_pkg::LAYER_W-1:0]        n_layer;
    logic [mctsl_pkg::SUM_W-1:0]          n_off;
    logic [mctsl_pkg::SUM_W-1:0]          n_end;
    logic                                 n_fits;

    mctsl_cfg_regs u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_cfg     (cfg),
        .o_geom_wr (geom_wr)
    );

    assign pready = 1'b1;

    mctsl_level_table u_lvl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_start   (geom_wr),
        .i_rd_en   (adv2),
        .i_rd_addr (r_lvl1[mctsl_pkg::LVL_AW-1:0]),
        .o_busy    (lt_busy),
        .o_rd      (lt_q),
        .o_stride  (lt_stride)
    );

    assign cam_wr = '{en:   in_acc && (i_op == mctsl_pkg::OP_STORE),
                      slot: i_slot,
                      id:   i_material_id};

    mctsl_layer_cam u_cam (
        .i_clk   (i_clk),
        .i_wr    (cam_wr),
        .i_id    (r_id1),
        .i_used  (cfg.used_layers),
        .o_match (cam_match)
    );

    assign adv6 = !r_v6 || i_ready;
    assign adv5 = !r_v5 || adv6;
    assign adv4 = !r_v4 || adv5;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign o_ready = adv1 && !lt_busy;
    assign in_acc  = i_valid && o_ready;

    assign n_bad1 = (int'(r_tex1) >= mctsl_pkg::TEXTURES) ||
                    (r_lvl1 >= mctsl_pkg::LVL_IN_W'(cfg.level_count));

    always_comb begin
        for (int g = 0; g < mctsl_pkg::NGRP; g++) begin
            n_ghit[g] = |r_match2[g*mctsl_pkg::GRP +: mctsl_pkg::GRP];
            n_gidx[g] = '0;
            for (int k = mctsl_pkg::GRP - 1; k >= 0; k--) begin
                if (r_match2[g*mctsl_pkg::GRP + k]) begin
                    n_gidx[g] = mctsl_pkg::GRP_AW'(k);
                end
            end
        end
    end

    always_comb begin
        n_hit   = 1'b0;
        n_layer = '0;
        for (int g = mctsl_pkg::NGRP - 1; g >= 0; g--) begin
            if (r_ghit3[g]) begin
                n_hit   = 1'b1;
                n_layer = mctsl_pkg::LAYER_W'(g * mctsl_pkg::GRP) +
                          mctsl_pkg::LAYER_W'(r_gidx3[g]);
            end
        end
    end

    assign n_off  = mctsl_pkg::SUM_W'(r_prod5) + mctsl_pkg::SUM_W'(r_before5);
    assign n_end  = mctsl_pkg::SUM_W'(r_prod5) + mctsl_pkg::SUM_W'(r_after5);
    assign n_fits = r_ok5 && (n_end <= mctsl_pkg::SUM_W'(cfg.store_bytes)) &&
                    ((r_bytes5 >> mctsl_pkg::CNT_OUT_W) == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= in_acc && (i_op == mctsl_pkg::OP_QUERY);
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
            if (adv5) begin
                r_v5 <= r_v4;
            end
            if (adv6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_id1  <= i_material_id;
            r_tex1 <= i_texture_slot;
            r_lvl1 <= i_level;
        end
        if (adv2) begin
            r_match2 <= mctsl_pkg::MPAD'(cam_match);
            r_bad2   <= n_bad1;
            r_tex2   <= mctsl_pkg::TEX_W'(r_tex1);
        end
        if (adv3) begin
            r_ghit3 <= n_ghit;
            r_gidx3 <= n_gidx;
            r_bad3  <= r_bad2;
            r_tex3  <= r_tex2;
            r_ent3  <= lt_q;
        end
        if (adv4) begin
            r_ok4     <= n_hit && !r_bad3;
            r_unit4   <= mctsl_pkg::UNIT_W'(n_layer) * mctsl_pkg::UNIT_W'(mctsl_pkg::TEXTURES) +
                         mctsl_pkg::UNIT_W'(r_tex3);
            r_before4 <= r_ent3.prior;
            r_bytes4  <= r_ent3.bytes;
            r_after4  <= mctsl_pkg::AFTER_W'(r_ent3.prior) +
                         mctsl_pkg::AFTER_W'(r_ent3.bytes);
        end
        if (adv5) begin
            r_ok5     <= r_ok4;
            r_prod5   <= mctsl_pkg::OFF_W'(r_unit4) * mctsl_pkg::OFF_W'(lt_stride);
            r_before5 <= r_before4;
            r_bytes5  <= r_bytes4;
            r_after5  <= r_after4;
        end
        if (adv6) begin
            r_found6 <= n_fits;
            r_off6   <= n_fits ? mctsl_pkg::OFF_OUT_W'(n_off) : '0;
            r_cnt6   <= n_fits ? mctsl_pkg::CNT_OUT_W'(r_bytes5) : '0;
        end
    end

    assign o_valid       = r_v6;
    assign o_found       = r_found6;
    assign o_byte_offset = r_off6;
    assign o_byte_count  = r_cnt6;

    a_no_accept_while_rebuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lt_busy |-> !o_ready)
        else $error("input beat taken during level table rebuild");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> (o_byte_offset == '0) && (o_byte_count == '0))
        else $error("missed lookup carries a nonzero span");

    a_hit_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> (o_byte_count != '0))
        else $error("found span has zero length");

    a_stage5_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v5 && adv6 |=> o_valid)
        else $error("beat lost between last two stages");

endmodule

`default_nettype wire

// ===== tb/mip_chain_texel_span_locator_unit_tb.sv =====
`timescale 1ns / 1ps

module mip_chain_texel_span_locator_unit_tb;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 10;
    localparam int REG_PAST_LIST   = 5;

    typedef struct {
        mctsl_pkg::t_op                 op;
        logic [mctsl_pkg::SLOT_W-1:0]   slot;
        logic [mctsl_pkg::ID_W-1:0]     id;
        logic [mctsl_pkg::TEX_IN_W-1:0] tex;
        logic [mctsl_pkg::LVL_IN_W-1:0] lvl;
    } t_locator_req;

    typedef struct packed {
        logic                            found;
        logic [mctsl_pkg::OFF_OUT_W-1:0] offset;
        logic [mctsl_pkg::CNT_OUT_W-1:0] count;
    } t_span;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_valid        = 1'b0;
    logic                            o_ready;
    logic                            i_op           = 1'b0;
    logic [mctsl_pkg::SLOT_W-1:0]    i_slot         = '0;
    logic [mctsl_pkg::ID_W-1:0]      i_material_id  = '0;
    logic [mctsl_pkg::TEX_IN_W-1:0]  i_texture_slot = '0;
    logic [mctsl_pkg::LVL_IN_W-1:0]  i_level        = '0;
    logic                            o_valid;
    logic                            i_ready        = 1'b0;
    logic                            o_found;
    logic [mctsl_pkg::OFF_OUT_W-1:0] o_byte_offset;
    logic [mctsl_pkg::CNT_OUT_W-1:0] o_byte_count;
    logic                            psel           = 1'b0;
    logic                            penable        = 1'b0;
    logic                            pwrite         = 1'b0;
    logic [mctsl_pkg::PADDR_W-1:0]   paddr          = '0;
    logic [mctsl_pkg::PDATA_W-1:0]   pwdata         = '0;
    logic [mctsl_pkg::PDATA_W-1:0]   prdata;
    logic                            pready;

    t_locator_req pending_beats[$];
    t_span        expected_spans[$];
    t_locator_req drive_beat;
    t_span        want;

    mctsl_pkg::t_cfg             cfg;
    logic [mctsl_pkg::ID_W-1:0]  slot_ids[mctsl_pkg::LAYERS];
    logic [mctsl_pkg::ID_W-1:0]  plan_ids[mctsl_pkg::LAYERS];
    bit                          plan_written[mctsl_pkg::LAYERS];

    bit          in_taken       = 1'b0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_requests  = 0;
    int unsigned hold_served    = 0;
    int unsigned hold_left      = 0;
    int unsigned span_errors    = 0;

    mip_chain_texel_span_locator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_slot         (i_slot),
        .i_material_id  (i_material_id),
        .i_texture_slot (i_texture_slot),
        .i_level        (i_level),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_found        (o_found),
        .o_byte_offset  (o_byte_offset),
        .o_byte_count   (o_byte_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint unsigned mip_bytes(int unsigned l);
        longint unsigned w, h;
        w = (l < 32) ? (64'(cfg.tex_width) >> l) : 64'd0;
        h = (l < 32) ? (64'(cfg.tex_height) >> l) : 64'd0;
        if (w == 0) w = 1;
        if (h == 0) h = 1;
        return w * h * mctsl_pkg::CHANNELS;
    endfunction

    function automatic t_span locate_span(logic [mctsl_pkg::ID_W-1:0] id,
                                          logic [mctsl_pkg::TEX_IN_W-1:0] tex,
                                          logic [mctsl_pkg::LVL_IN_W-1:0] lvl);
        t_span           s;
        int unsigned     used, layer, i;
        bit              hit;
        longint unsigned stride, below, cnt, off;
        s      = '0;
        hit    = 1'b0;
        layer  = 0;
        stride = 0;
        below  = 0;
        if (tex >= mctsl_pkg::TEXTURES || lvl >= cfg.level_count) return s;
        used = (cfg.used_layers < mctsl_pkg::LAYERS) ? cfg.used_layers : mctsl_pkg::LAYERS;
        for (i = 0; i < used && !hit; i++) begin
            if (slot_ids[i] == id) begin
                layer = i;
                hit   = 1'b1;
            end
        end
        if (!hit) return s;
        for (i = 0; i < cfg.level_count; i++) begin
            stride += mip_bytes(i);
            if (i < lvl) below += mip_bytes(i);
        end
        cnt = mip_bytes(lvl);
        off = 64'(layer) * stride * mctsl_pkg::TEXTURES + 64'(tex) * stride + below;
        if (off > cfg.store_bytes || cnt > cfg.store_bytes - off) return s;
        if (cnt >= (64'd1 << mctsl_pkg::CNT_OUT_W)) return s;
        s.found  = 1'b1;
        s.offset = off[mctsl_pkg::OFF_OUT_W-1:0];
        s.count  = cnt[mctsl_pkg::CNT_OUT_W-1:0];
        return s;
    endfunction

    task automatic queue_beat(mctsl_pkg::t_op op, logic [mctsl_pkg::SLOT_W-1:0] slot,
                              logic [mctsl_pkg::ID_W-1:0] id,
                              logic [mctsl_pkg::TEX_IN_W-1:0] tex,
                              logic [mctsl_pkg::LVL_IN_W-1:0] lvl);
        t_locator_req b;
        b.op   = op;
        b.slot = slot;
        b.id   = id;
        b.tex  = tex;
        b.lvl  = lvl;
        if (op == mctsl_pkg::OP_STORE) begin
            plan_ids[slot]     = id;
            plan_written[slot] = 1'b1;
        end
        pending_beats.insert(pending_beats.size(), b);
    endtask

    task automatic queue_random_item();
        mctsl_pkg::t_op                 op;
        logic [mctsl_pkg::SLOT_W-1:0]   slot;
        logic [mctsl_pkg::ID_W-1:0]     id;
        logic [mctsl_pkg::TEX_IN_W-1:0] tex;
        logic [mctsl_pkg::LVL_IN_W-1:0] lvl;
        int unsigned                    used, lc, j, k;
        int                             gap;
        used = (cfg.used_layers < mctsl_pkg::LAYERS) ? cfg.used_layers : mctsl_pkg::LAYERS;
        lc   = cfg.level_count;
        slot = mctsl_pkg::SLOT_W'($urandom_range(0, mctsl_pkg::LAYERS - 1));
        tex  = mctsl_pkg::TEX_IN_W'($urandom_range(0, 255));
        lvl  = mctsl_pkg::LVL_IN_W'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) != 0) id = mctsl_pkg::ID_W'($urandom_range(0, 65535));
        else id = mctsl_pkg::ID_W'(16'hC3A0 + $urandom_range(0, 7));
        op = ($urandom_range(0, 99) < 75) ? mctsl_pkg::OP_QUERY : mctsl_pkg::OP_STORE;
        if (op == mctsl_pkg::OP_QUERY) begin
            j = (used != 0) ? $urandom_range(0, used - 1) : 0;
            if (used != 0 && plan_written[j] && $urandom_range(0, 99) < 70) id = plan_ids[j];
            if ($urandom_range(0, 99) < 85)
                tex = mctsl_pkg::TEX_IN_W'($urandom_range(0, mctsl_pkg::TEXTURES - 1));
            if (lc != 0 && $urandom_range(0, 99) < 85)
                lvl = mctsl_pkg::LVL_IN_W'($urandom_range(0, lc - 1));
            if (tex < mctsl_pkg::TEXTURES && lvl < lc) begin
                gap = -1;
                for (k = 0; k < used; k++) begin
                    if (!plan_written[k]) begin
                        gap = k;
                        break;
                    end
                    if (plan_ids[k] == id) break;
                end
                if (gap >= 0) begin
                    op   = mctsl_pkg::OP_STORE;
                    slot = gap[mctsl_pkg::SLOT_W-1:0];
                end
            end
        end
        queue_beat(op, slot, id, tex, lvl);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pending_beats.size() != 0 || i_valid || expected_spans.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(int idx, logic [mctsl_pkg::PDATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= mctsl_pkg::PADDR_W'(idx * 4);
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        case (idx)
            mctsl_pkg::REG_TEX_WIDTH:   cfg.tex_width   = val[mctsl_pkg::DIM_W-1:0];
            mctsl_pkg::REG_TEX_HEIGHT:  cfg.tex_height  = val[mctsl_pkg::DIM_W-1:0];
            mctsl_pkg::REG_LEVEL_COUNT: cfg.level_count = val[mctsl_pkg::LVLC_W-1:0];
            mctsl_pkg::REG_USED_LAYERS: cfg.used_layers = val[mctsl_pkg::USED_W-1:0];
            mctsl_pkg::REG_STORE_BYTES: cfg.store_bytes = val[mctsl_pkg::STORE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_phase(int unsigned w, int unsigned h, int unsigned lc,
                             int unsigned used, int unsigned store, int unsigned send_pct,
                             int unsigned recv_pct, int unsigned n, bit pressure);
        drain();
        write_reg(mctsl_pkg::REG_TEX_WIDTH, w);
        write_reg(mctsl_pkg::REG_TEX_HEIGHT, h);
        write_reg(mctsl_pkg::REG_LEVEL_COUNT, lc);
        write_reg(mctsl_pkg::REG_USED_LAYERS, used);
        write_reg(mctsl_pkg::REG_STORE_BYTES, store);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (pressure) begin
            hold_requests++;
            repeat (n / 2) queue_random_item();
            drain();
            n = n - n / 2;
        end
        repeat (n) queue_random_item();
    endtask

    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                drive_beat = pending_beats.pop_front();
                i_valid        <= 1'b1;
                i_op           <= drive_beat.op;
                i_slot         <= drive_beat.slot;
                i_material_id  <= drive_beat.id;
                i_texture_slot <= drive_beat.tex;
                i_level        <= drive_beat.lvl;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_spans.size() == 0) begin
                span_errors++;
                if (span_errors <= 10)
                    $display("unexpected result beat: found=%0d offset=%0d count=%0d",
                             o_found, o_byte_offset, o_byte_count);
            end else begin
                want = expected_spans.pop_front();
                if (o_found !== want.found || o_byte_offset !== want.offset ||
                    o_byte_count !== want.count) begin
                    span_errors++;
                    if (span_errors <= 10)
                        $display({"span mismatch: expected found=%0d offset=%0d count=%0d, ",
                                  "got found=%0d offset=%0d count=%0d"},
                                 want.found, want.offset, want.count,
                                 o_found, o_byte_offset, o_byte_count);
                end
            end
        end
        if (in_taken) begin
            if (i_op == mctsl_pkg::OP_STORE) slot_ids[i_slot] = i_material_id;
            else expected_spans.insert(expected_spans.size(),
                                       locate_span(i_material_id, i_texture_slot, i_level));
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        cfg.tex_width   = 16;
        cfg.tex_height  = 16;
        cfg.level_count = 5;
        cfg.used_layers = 0;
        cfg.store_bytes = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'h0000, 0, 0);
        queue_beat(mctsl_pkg::OP_QUERY, 6'h3F, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'h0001, mctsl_pkg::TEXTURES, 0);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'h0001, mctsl_pkg::TEXTURES - 1, 5);
        queue_beat(mctsl_pkg::OP_STORE, 0, 16'hFFFF, 8'hFF, 16'hFFFF);
        queue_beat(mctsl_pkg::OP_STORE, 6'h3F, 16'h0000, 0, 0);
        queue_beat(mctsl_pkg::OP_STORE, 1, 16'hA5A5, 0, 0);
        queue_beat(mctsl_pkg::OP_STORE, 2, 16'h5A5A, 0, 0);
        queue_beat(mctsl_pkg::OP_STORE, 3, 16'hA5A5, 0, 0);
        drain();
        write_reg(mctsl_pkg::REG_USED_LAYERS, 4);
        write_reg(mctsl_pkg::REG_STORE_BYTES, 21824);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'hFFFF, 0, 0);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'hA5A5, 3, 4);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'h0000, 1, 2);
        queue_beat(mctsl_pkg::OP_STORE, 3, 16'h0000, 0, 0);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'h0000, 3, 4);
        drain();
        write_reg(mctsl_pkg::REG_STORE_BYTES, 21823);
        write_reg(REG_PAST_LIST, 32'hFFFF_FFFF);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'h0000, 3, 4);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'hFFFF, 0, 0);
        queue_beat(mctsl_pkg::OP_QUERY, 0, 16'h5A5A, 2, 3);

        run_phase(16, 16, 5, 64, 536870912, 0, 0, 100, 1'b1);
        run_phase(4096, 4096, 13, 64, 536870912, 47, 0, 80, 1'b0);
        run_phase(64, 32, 7, 40, 200000, 0, 47, 100, 1'b0);
        run_phase(4096, 16, 13, 3, 1048576, 20, 20, 80, 1'b0);
        run_phase(8191, 8191, 15, 127, 1073741823, 0, 0, 60, 1'b0);
        run_phase(16, 4096, 0, 0, 0, 47, 0, 40, 1'b0);
        run_phase(32, 32, 6, 64, 30000, 0, 47, 100, 1'b0);
        run_phase(16, 16, 1, 1, 1024, 20, 20, 40, 1'b0);
        drain();

        if (span_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mctsl_pkg.sv
rtl/core/mctsl_cfg_regs.sv
rtl/core/mctsl_level_table.sv
rtl/core/mctsl_layer_cam.sv
rtl/core/mip_chain_texel_span_locator_unit.sv
tb/mip_chain_texel_span_locator_unit_tb.sv
